[hw/rtl/pwmts_pkg.sv]
package pwmts_pkg;

  // Fixed field widths.
  localparam int unsigned ClkW    = 29;
  localparam int unsigned FreqW   = 20;
  localparam int unsigned DutyW   = 14;
  localparam int unsigned RegW    = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PpmW    = 21;
  localparam int unsigned PerW    = 17;   // period counts up to 65536
  localparam int unsigned DivW    = 14;   // prescaler divisor up to 8192
  localparam int unsigned PctW    = 7;    // duty in whole percent
  localparam int unsigned TotW    = 30;   // divisor times period
  localparam int unsigned OpW     = 50;   // shared divider operand width
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InW     = 40;
  localparam int unsigned OutW    = 144;

  // Defaults and constants.
  localparam int unsigned CounterPeriodMaxDef = 65536;
  localparam int unsigned PeriodMinDef        = 100;
  localparam logic [ClkW-1:0]  ClkReset   = 29'd84000000;
  localparam logic [FreqW-1:0] MinReset   = 20'd1;
  localparam logic [FreqW-1:0] MaxReset   = 20'd840000;
  localparam logic [DutyW-1:0] DutyFull   = 14'd10000;
  localparam logic [FreqW-1:0] FreqLimit  = 20'd1048575;
  localparam logic [PctW-1:0]  PctFull    = 7'd100;
  localparam logic [OpW-1:0]   Million    = 50'd1000000;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgClk = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMin = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMax = 2'd2;

  // Output modes.
  localparam logic [ModeW-1:0] ModeLow  = 2'd0;
  localparam logic [ModeW-1:0] ModePwm  = 2'd1;
  localparam logic [ModeW-1:0] ModeHigh = 2'd2;

  // Division steps of one request.
  typedef enum logic [2:0] {
    PH_DIV = 3'd0,
    PH_PER = 3'd1,
    PH_CCR = 3'd2,
    PH_AD  = 3'd3,
    PH_FRQ = 3'd4,
    PH_PPM = 3'd5
  } phase_e;

  typedef struct packed {
    logic   load_req;
    logic   prep;
    logic   start;
    logic   capture;
    phase_e phase;
    logic   commit_en;
    logic   commit_dis;
    logic   set_result;
    logic   result_ok;
  } cmd_t;

  typedef struct packed {
    logic en;
    logic dis_ok;
    logic range_ok;
    logic period_ok;
    logic pwm_mode;
    logic div_done;
  } status_t;

endpackage

[hw/rtl/pwmts_div.sv]
module pwmts_div #(
  parameter int unsigned W = pwmts_pkg::OpW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    num_q, den_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      trial;
  logic            fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, num_q[W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], fits};
      rem_q <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/pwmts_datapath.sv]
module pwmts_datapath #(
  parameter int unsigned PERIOD_MIN = pwmts_pkg::PeriodMinDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pwmts_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pwmts_pkg::ClkW-1:0]          cfg_wdata_i,
  input  logic [pwmts_pkg::InW-1:0]           in_data_i,
  input  pwmts_pkg::cmd_t                     cmd_i,
  output pwmts_pkg::status_t                  status_o,
  output logic [pwmts_pkg::OutW-1:0]          out_data_o
);

  localparam int unsigned OpW = pwmts_pkg::OpW;

  logic [pwmts_pkg::ClkW-1:0]  clk_cfg_q;
  logic [pwmts_pkg::FreqW-1:0] min_q, max_q;
  logic [OpW-1:0]              clkm_q;

  logic                         en_q;
  logic [pwmts_pkg::FreqW-1:0]  hz_q;
  logic [pwmts_pkg::DutyW-1:0]  duty_q;
  logic [pwmts_pkg::PctW-1:0]   pct_q;
  logic [pwmts_pkg::DivW-1:0]   div_q;
  logic [pwmts_pkg::PerW-1:0]   period_q, ccr_q;
  logic [pwmts_pkg::DutyW-1:0]  ad_q;
  logic [pwmts_pkg::TotW-1:0]   total_q;
  logic [pwmts_pkg::FreqW-1:0]  afreq_q;
  logic [pwmts_pkg::PpmW-1:0]   ppm_q;
  logic [OpW-1:0]               prod_q;
  logic                         acc_q;

  // Architectural state.
  logic [pwmts_pkg::FreqW-1:0] goal_f_q, ach_f_q;
  logic [pwmts_pkg::PpmW-1:0]  err_q;
  logic [pwmts_pkg::DutyW-1:0] goal_d_q, ach_d_q;
  logic [pwmts_pkg::RegW-1:0]  pre_q, rel_q, cmp_q;
  logic [pwmts_pkg::ModeW-1:0] mode_q;
  logic                        on_q;

  logic [OpW-1:0] num, den, quo, rem;
  logic           done;
  logic [27:0]    pct_mul;
  logic [OpW-1:0] prod_d;
  logic [pwmts_pkg::PerW-1:0] per_m1;
  logic [pwmts_pkg::PpmW:0]   ppm_neg;
  logic [22:0]                ccr_num;
  logic [46:0]                ccr_mul;
  logic [pwmts_pkg::PerW-1:0] ccr_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_cfg_q <= pwmts_pkg::ClkReset;
      min_q     <= pwmts_pkg::MinReset;
      max_q     <= pwmts_pkg::MaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwmts_pkg::CfgClk: clk_cfg_q <= cfg_wdata_i;
        pwmts_pkg::CfgMin: min_q     <= cfg_wdata_i[pwmts_pkg::FreqW-1:0];
        pwmts_pkg::CfgMax: max_q     <= cfg_wdata_i[pwmts_pkg::FreqW-1:0];
        default: ;
      endcase
    end
  end

  // Clock times one million, the numerator of the error division.
  always_ff @(posedge clk_i) begin
    clkm_q <= OpW'(clk_cfg_q) * pwmts_pkg::Million;
  end

  // Duty rounded to whole percent: (duty + 50) / 100 by reciprocal.
  assign pct_mul = 28'(({1'b0, in_data_i[34:21]} + 15'd50)) * 28'd5243;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      en_q   <= in_data_i[0];
      hz_q   <= in_data_i[20:1];
      duty_q <= in_data_i[34:21];
      pct_q  <= pct_mul[25:19];
    end
  end

  always_comb begin
    prod_d = prod_q;
    case (cmd_i.phase)
      pwmts_pkg::PH_DIV: prod_d = OpW'(hz_q) * OpW'(pwmts_pkg::CounterPeriodMaxDef);
      pwmts_pkg::PH_PER: prod_d = OpW'(hz_q) * OpW'(div_q);
      pwmts_pkg::PH_CCR: prod_d = OpW'(period_q) * OpW'(pct_q);
      pwmts_pkg::PH_AD:  prod_d = OpW'(ccr_q) * OpW'(pwmts_pkg::DutyFull);
      pwmts_pkg::PH_FRQ: prod_d = OpW'(div_q) * OpW'(period_q);
      pwmts_pkg::PH_PPM: prod_d = OpW'(hz_q) * OpW'(total_q);
      default:           prod_d = prod_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      prod_q <= prod_d;
      if (cmd_i.phase == pwmts_pkg::PH_FRQ) total_q <= prod_d[pwmts_pkg::TotW-1:0];
    end
  end

  // The compare value divides by a constant 100, done by reciprocal; the
  // product of period and percent stays below 2^23.
  assign ccr_num = 23'(prod_q) + 23'd50;
  assign ccr_mul = 47'(ccr_num) * 47'd10737419;
  assign ccr_quo = ccr_mul[46:30];

  always_comb begin
    num = '0;
    den = prod_q;
    case (cmd_i.phase)
      pwmts_pkg::PH_DIV: num = OpW'(clk_cfg_q) + prod_q - OpW'(1);
      pwmts_pkg::PH_PER: num = OpW'(clk_cfg_q) + (prod_q >> 1);
      pwmts_pkg::PH_AD: begin
        num = prod_q + OpW'(period_q >> 1);
        den = OpW'(period_q);
      end
      pwmts_pkg::PH_FRQ: num = OpW'(clk_cfg_q) + (prod_q >> 1);
      pwmts_pkg::PH_PPM: num = clkm_q;
      default: num = '0;
    endcase
  end

  pwmts_div #(.W(OpW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  assign per_m1  = period_q - 1'b1;
  // Error when the clock is below target: ceil(clk * 1e6 / D) - 1e6.
  assign ppm_neg = 22'(quo) + 22'(rem != '0) - 22'd1000000;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      case (cmd_i.phase)
        pwmts_pkg::PH_DIV: div_q <= (quo == '0) ? pwmts_pkg::DivW'(1) : quo[pwmts_pkg::DivW-1:0];
        pwmts_pkg::PH_PER: period_q <= quo[pwmts_pkg::PerW-1:0];
        pwmts_pkg::PH_CCR: ccr_q <= (ccr_quo >= period_q) ? per_m1 : ccr_quo;
        pwmts_pkg::PH_AD:  ad_q <= quo[pwmts_pkg::DutyW-1:0];
        pwmts_pkg::PH_FRQ: afreq_q <= (quo > OpW'(pwmts_pkg::FreqLimit)) ?
                                      pwmts_pkg::FreqLimit : quo[pwmts_pkg::FreqW-1:0];
        pwmts_pkg::PH_PPM: begin
          if (OpW'(clk_cfg_q) >= prod_q) begin
            ppm_q <= (quo > OpW'(2000000)) ? pwmts_pkg::PpmW'(1000000)
                                           : pwmts_pkg::PpmW'(quo - pwmts_pkg::Million);
          end else begin
            ppm_q <= ppm_neg[pwmts_pkg::PpmW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_f_q <= 20'd1000;
      ach_f_q  <= 20'd1000;
      err_q    <= '0;
      goal_d_q <= 14'd5000;
      ach_d_q  <= 14'd5000;
      pre_q    <= 16'd83;
      rel_q    <= 16'd999;
      cmp_q    <= 16'd500;
      mode_q   <= pwmts_pkg::ModePwm;
      on_q     <= 1'b0;
      acc_q    <= 1'b0;
    end else begin
      if (cmd_i.set_result) acc_q <= cmd_i.result_ok;
      if (cmd_i.commit_dis) begin
        cmp_q   <= '0;
        mode_q  <= pwmts_pkg::ModeLow;
        ach_d_q <= '0;
        on_q    <= 1'b0;
      end else if (cmd_i.commit_en) begin
        goal_f_q <= hz_q;
        ach_f_q  <= afreq_q;
        err_q    <= ppm_q;
        goal_d_q <= pwmts_pkg::DutyW'(pct_q) * 14'd100;
        pre_q    <= pwmts_pkg::RegW'(div_q - 1'b1);
        rel_q    <= per_m1[pwmts_pkg::RegW-1:0];
        on_q     <= 1'b1;
        if (pct_q == '0) begin
          mode_q  <= pwmts_pkg::ModeLow;
          cmp_q   <= '0;
          ach_d_q <= '0;
        end else if (pct_q == pwmts_pkg::PctFull) begin
          mode_q  <= pwmts_pkg::ModeHigh;
          cmp_q   <= per_m1[pwmts_pkg::RegW-1:0];
          ach_d_q <= pwmts_pkg::DutyFull;
        end else begin
          mode_q  <= pwmts_pkg::ModePwm;
          cmp_q   <= ccr_q[pwmts_pkg::RegW-1:0];
          ach_d_q <= ad_q;
        end
      end
    end
  end

  assign status_o.en        = en_q;
  assign status_o.dis_ok    = (hz_q == '0) && (duty_q == '0);
  assign status_o.range_ok  = (duty_q <= pwmts_pkg::DutyFull) && (hz_q != '0) &&
                              (hz_q >= min_q) && (hz_q <= max_q);
  assign status_o.period_ok = (period_q >= pwmts_pkg::PerW'(PERIOD_MIN)) &&
                              (period_q <= pwmts_pkg::PerW'(pwmts_pkg::CounterPeriodMaxDef));
  assign status_o.pwm_mode  = (pct_q != '0) && (pct_q != pwmts_pkg::PctFull);
  assign status_o.div_done  = done;

  assign out_data_o = {3'b000, ach_d_q, goal_d_q, goal_f_q, err_q, ach_f_q, mode_q,
                       cmp_q, rel_q, pre_q, on_q, acc_q};

endmodule

[hw/rtl/pwmts_ctrl.sv]
module pwmts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pwmts_pkg::status_t status_i,
  output pwmts_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_START = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  pwmts_pkg::phase_e phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.phase = phase_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!status_i.en) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result_ok  = status_i.dis_ok;
          cmd_o.commit_dis = status_i.dis_ok;
          state_d = S_OUT;
        end else if (status_i.range_ok) begin
          phase_d = pwmts_pkg::PH_DIV;
          state_d = S_PREP;
        end else begin
          cmd_o.set_result = 1'b1;
          state_d = S_OUT;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = S_START;
      end
      S_START: begin
        // The compare step needs no divider and is captured right away.
        if (phase_q == pwmts_pkg::PH_CCR) begin
          cmd_o.capture = 1'b1;
          state_d = S_NEXT;
        end else begin
          cmd_o.start = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd_o.capture = status_i.div_done;
        if (status_i.div_done) state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = S_PREP;
        case (phase_q)
          pwmts_pkg::PH_DIV: phase_d = pwmts_pkg::PH_PER;
          pwmts_pkg::PH_PER: begin
            if (!status_i.period_ok) begin
              cmd_o.set_result = 1'b1;
              state_d = S_OUT;
            end else if (status_i.pwm_mode) begin
              phase_d = pwmts_pkg::PH_CCR;
            end else begin
              phase_d = pwmts_pkg::PH_FRQ;
            end
          end
          pwmts_pkg::PH_CCR: phase_d = pwmts_pkg::PH_AD;
          pwmts_pkg::PH_AD:  phase_d = pwmts_pkg::PH_FRQ;
          pwmts_pkg::PH_FRQ: phase_d = pwmts_pkg::PH_PPM;
          default: begin
            cmd_o.commit_en  = 1'b1;
            cmd_o.set_result = 1'b1;
            cmd_o.result_ok  = 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= pwmts_pkg::PH_DIV;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

[hw/rtl/pwm_timer_parameter_solver_core.sv]
// Channel  | Direction | Signals                      | Contents
// request  | in        | s_axis_tvalid/tready/tdata   | enable, frequency, duty
// result   | out       | m_axis_tvalid/tready/tdata   | acceptance and timer settings
// config   | in        | cfg_we_i/cfg_idx_i/cfg_wdata_i | clock, min and max frequency
//
// An enabled item in pwm mode takes five divisions through one shared 50-bit
// restoring divider at one quotient bit per cycle, plus a compare step by reciprocal.
// Forced low or high takes four divisions; a period rejection stops after the
// period division. Disable and range rejections skip the divider altogether.
// Reset is asynchronous and active low; it restores the default timer settings.
// A new item is taken only after the previous result has been handed off.
module pwm_timer_parameter_solver_core #(
  parameter int unsigned PERIOD_MIN = pwmts_pkg::PeriodMinDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwmts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pwmts_pkg::ClkW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // enable_request[0], request_frequency_hz[20:1], request_duty[34:21], zero pad
  input  logic [pwmts_pkg::InW-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // accepted[0], output_enabled[1], prescale_value[17:2], reload_value[33:18],
  // compare_value[49:34], output_mode[51:50], achieved_frequency_hz[71:52],
  // frequency_error_ppm[92:72], goal_frequency_hz[112:93], goal_duty[126:113],
  // achieved_duty[140:127], zero pad
  output logic [pwmts_pkg::OutW-1:0]    m_axis_tdata
);

  pwmts_pkg::cmd_t    cmd;
  pwmts_pkg::status_t status;

  // The controller sequences the division steps of one item.
  pwmts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the timer state and the divider.
  pwmts_datapath #(
    .PERIOD_MIN (PERIOD_MIN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[test/testbench.sv]
module testbench;
  import pwmts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One request as it travels on the slave side of the block.
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [FreqW-1:0] freq;
    logic             enable;
  } request_t;

  // One result, with the fields named as the block reports them.
  typedef struct {
    logic             accepted;
    logic             enabled;
    logic [RegW-1:0]  prescale;
    logic [RegW-1:0]  reload;
    logic [RegW-1:0]  compare;
    logic [ModeW-1:0] mode;
    logic [FreqW-1:0] afreq;
    logic signed [PpmW-1:0] ppm;
    logic [FreqW-1:0] gfreq;
    logic [DutyW-1:0] gduty;
    logic [DutyW-1:0] aduty;
  } settings_t;

  // A row of the directed table. When has_fixed is set, the row also carries the
  // expected result as typed in, which is checked against the predictor; the block
  // is checked against the predictor in turn.
  typedef struct {
    logic             enable;
    int unsigned      freq;
    int unsigned      duty;
    bit               has_fixed;
    settings_t        fixed;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ClkW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  pwm_timer_parameter_solver_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the configuration and of the timer settings.
  longint unsigned timer_clk, min_hz, max_hz;
  settings_t timer_state;

  // Expected results, oldest first, and the bookkeeping of the checker.
  settings_t pending_settings[$];
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  int unsigned accept_count = 0;
  int unsigned reject_count = 0;
  int unsigned mode_seen[3] = '{0, 0, 0};
  bit stimulus_done = 1'b0;

  // The receiver reads the first two: a long hold-off, and whether it idles; the sender reads the last.
  int unsigned hold_off_cycles = 0;
  bit sink_busy_mode = 1'b1;
  bit source_busy_mode = 1'b1;

  function automatic settings_t reset_settings();
    settings_t s;
    s.accepted = 1'b0;
    s.enabled  = 1'b0;
    s.prescale = 16'd83;
    s.reload   = 16'd999;
    s.compare  = 16'd500;
    s.mode     = ModePwm;
    s.afreq    = 20'd1000;
    s.ppm      = '0;
    s.gfreq    = 20'd1000;
    s.gduty    = 14'd5000;
    s.aduty    = 14'd5000;
    return s;
  endfunction

  // Solve one enable request against the current configuration. Returns 0 when
  // the request must be rejected, leaving the settings as they are.
  function automatic bit solve_timer(input longint unsigned hz, input longint unsigned duty,
                                     inout settings_t s);
    longint unsigned den, div, period, pct, ccr, ad, total, afreq;
    longint signed num, ppm;
    logic [ModeW-1:0] mode;
    if (duty > 10000) return 1'b0;
    if (hz == 0 || hz < min_hz || hz > max_hz) return 1'b0;
    den = hz * 65536;
    div = (timer_clk + den - 1) / den;
    if (div < 1) div = 1;
    if (div > 65536) return 1'b0;
    den = hz * div;
    period = (timer_clk + den / 2) / den;
    if (period < 100 || period > 65536) return 1'b0;
    pct = ((duty + 50) / 100);
    if (pct > 100) pct = 100;
    if (pct == 0) begin
      mode = ModeLow;
      ccr = 0;
      ad = 0;
    end else if (pct == 100) begin
      mode = ModeHigh;
      ccr = period - 1;
      ad = 10000;
    end else begin
      mode = ModePwm;
      ccr = (period * pct + 50) / 100;
      if (ccr >= period) ccr = period - 1;
      ad = (ccr * 10000 + period / 2) / period;
    end
    total = div * period;
    afreq = (timer_clk + total / 2) / total;
    if (afreq > 1048575) afreq = 1048575;
    num = longint'(timer_clk) - longint'(hz * total);
    ppm = (num * 1000000) / longint'(hz * total);
    if (ppm > 1000000) ppm = 1000000;
    if (ppm < -1000000) ppm = -1000000;
    s.gfreq    = hz[FreqW-1:0];
    s.afreq    = afreq[FreqW-1:0];
    s.ppm      = ppm[PpmW-1:0];
    s.gduty    = DutyW'(pct * 100);
    s.aduty    = ad[DutyW-1:0];
    s.prescale = RegW'(div - 1);
    s.reload   = RegW'(period - 1);
    s.compare  = ccr[RegW-1:0];
    s.mode     = mode;
    s.enabled  = 1'b1;
    return 1'b1;
  endfunction

  // Apply one request to the predictor and return the expected result.
  function automatic settings_t apply_request(input request_t r);
    bit ok;
    settings_t s;
    s = timer_state;
    if (!r.enable) begin
      ok = (r.freq == 0 && r.duty == 0);
      if (ok) begin
        s.compare = '0;
        s.mode    = ModeLow;
        s.aduty   = '0;
        s.enabled = 1'b0;
      end
    end else begin
      ok = solve_timer(r.freq, r.duty, s);
    end
    s.accepted = ok;
    timer_state = s;
    return s;
  endfunction

  function automatic settings_t unpack_result(input logic [OutW-1:0] d);
    settings_t s;
    s.accepted = d[0];
    s.enabled  = d[1];
    s.prescale = d[17:2];
    s.reload   = d[33:18];
    s.compare  = d[49:34];
    s.mode     = d[51:50];
    s.afreq    = d[71:52];
    s.ppm      = d[92:72];
    s.gfreq    = d[112:93];
    s.gduty    = d[126:113];
    s.aduty    = d[140:127];
    return s;
  endfunction

  // Field-by-field comparison; the tag says where the mismatch came from.
  function automatic void compare_settings(input string tag, input settings_t exp_s,
                                           input settings_t act);
    if (act.accepted !== exp_s.accepted) begin
      $error("%s accepted: expected %0d, got %0d", tag, exp_s.accepted, act.accepted);
      fail_count++;
    end
    if (act.enabled !== exp_s.enabled) begin
      $error("%s output_enabled: expected %0d, got %0d", tag, exp_s.enabled, act.enabled);
      fail_count++;
    end
    if (act.prescale !== exp_s.prescale) begin
      $error("%s prescale_value: expected %0d, got %0d", tag, exp_s.prescale, act.prescale);
      fail_count++;
    end
    if (act.reload !== exp_s.reload) begin
      $error("%s reload_value: expected %0d, got %0d", tag, exp_s.reload, act.reload);
      fail_count++;
    end
    if (act.compare !== exp_s.compare) begin
      $error("%s compare_value: expected %0d, got %0d", tag, exp_s.compare, act.compare);
      fail_count++;
    end
    if (act.mode !== exp_s.mode) begin
      $error("%s output_mode: expected %0d, got %0d", tag, exp_s.mode, act.mode);
      fail_count++;
    end
    if (act.afreq !== exp_s.afreq) begin
      $error("%s achieved_frequency_hz: expected %0d, got %0d", tag, exp_s.afreq, act.afreq);
      fail_count++;
    end
    if (act.ppm !== exp_s.ppm) begin
      $error("%s frequency_error_ppm: expected %0d, got %0d", tag, exp_s.ppm, act.ppm);
      fail_count++;
    end
    if (act.gfreq !== exp_s.gfreq) begin
      $error("%s goal_frequency_hz: expected %0d, got %0d", tag, exp_s.gfreq, act.gfreq);
      fail_count++;
    end
    if (act.gduty !== exp_s.gduty) begin
      $error("%s goal_duty: expected %0d, got %0d", tag, exp_s.gduty, act.gduty);
      fail_count++;
    end
    if (act.aduty !== exp_s.aduty) begin
      $error("%s achieved_duty: expected %0d, got %0d", tag, exp_s.aduty, act.aduty);
      fail_count++;
    end
  endfunction

  // Result checker. Outputs are sampled at the rising edge, before the
  // nonblocking updates of this step land, so the handshake seen here is the
  // one that completes at this edge.
  always @(posedge clk_i) begin
    settings_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_result(m_axis_tdata);
      result_count++;
      if (pending_settings.size() == 0) begin
        $error("result with nothing expected: accepted %0d", got.accepted);
        fail_count++;
      end else begin
        compare_settings("result", pending_settings.pop_front(), got);
      end
      if (got.accepted) accept_count++;
      else reject_count++;
      if (got.mode <= ModeHigh) mode_seen[got.mode]++;
    end
  end

  // Receiver: random back-pressure, a stretch without it, and a long hold-off
  // when the stimulus asks for one. The hold-off is counted here in cycles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_busy_mode) begin
      m_axis_tready <= ($urandom_range(99) >= 35);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one request and wait until it is taken. Its expected result is queued
  // at the edge of the handshake so it is in place before the result can come.
  // Valid stays high after the handshake only until the next request or drain
  // takes over in the same time step.
  task automatic send_request(input request_t r);
    while (source_busy_mode && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= InW'(r);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_settings.push_back(apply_request(r));
  endtask

  // Let every expected result arrive, then let the clock run on so the block is
  // surely idle before the next register write.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input longint unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[ClkW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgClk: timer_clk = value & 64'h1FFF_FFFF;
      CfgMin: min_hz = value & 64'hF_FFFF;
      CfgMax: max_hz = value & 64'hF_FFFF;
      default: ;
    endcase
  endtask

  // Random request. Most are valid enables inside the configured range, the rest
  // are disables, out-of-range frequencies, bad duties and raw noise.
  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    longint unsigned lo, hi;
    pick = $urandom_range(99);
    r.enable = 1'b1;
    lo = (min_hz == 0) ? 1 : min_hz;
    hi = (max_hz < lo) ? lo : max_hz;
    if (pick < 60) begin
      // Mostly low frequencies, where the prescaler and period both vary widely.
      if ($urandom_range(3) == 0) r.freq = FreqW'($urandom_range(hi, lo));
      else r.freq = FreqW'($urandom_range((hi < lo + 5000) ? hi : lo + 5000, lo));
      case ($urandom_range(4))
        0: r.duty = DutyW'($urandom_range(49));
        1: r.duty = DutyW'($urandom_range(10000, 9950));
        default: r.duty = DutyW'($urandom_range(10000));
      endcase
    end else if (pick < 72) begin
      r.enable = 1'b0;
      r.freq = '0;
      r.duty = '0;
    end else if (pick < 80) begin
      r.enable = 1'b0;
      r.freq = FreqW'($urandom_range(3));
      r.duty = DutyW'($urandom_range(3));
    end else if (pick < 88) begin
      r.freq = FreqW'($urandom_range(hi, lo));
      r.duty = DutyW'($urandom_range(16383, 10001));
    end else begin
      r = request_t'($urandom());
      r.duty = DutyW'($urandom());
    end
    return r;
  endfunction

  // Directed table under the reset configuration (84 MHz, 1 Hz .. 840 kHz).
  directed_row_t directed_rows[$];

  function automatic settings_t fixed_row(input bit acc, input bit en, input int unsigned pre,
                                          input int unsigned rel, input int unsigned cmp,
                                          input logic [ModeW-1:0] mode,
                                          input int unsigned afreq, input int ppm,
                                          input int unsigned gfreq, input int unsigned gduty,
                                          input int unsigned aduty);
    settings_t s;
    s.accepted = acc;
    s.enabled = en;
    s.prescale = RegW'(pre);
    s.reload = RegW'(rel);
    s.compare = RegW'(cmp);
    s.mode = mode;
    s.afreq = FreqW'(afreq);
    s.ppm = PpmW'(ppm);
    s.gfreq = FreqW'(gfreq);
    s.gduty = DutyW'(gduty);
    s.aduty = DutyW'(aduty);
    return s;
  endfunction

  function automatic void add_row(input logic en, input int unsigned hz, input int unsigned duty);
    directed_row_t row;
    row.enable = en;
    row.freq = hz;
    row.duty = duty;
    row.has_fixed = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_fixed_row(input logic en, input int unsigned hz,
                                        input int unsigned duty, input settings_t s);
    directed_row_t row;
    row.enable = en;
    row.freq = hz;
    row.duty = duty;
    row.has_fixed = 1'b1;
    row.fixed = s;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_table();
    settings_t rst_s;
    rst_s = reset_settings();
    // A rejected request right after reset reports the reset settings.
    add_fixed_row(1'b1, 1000, 10001, rst_s);
    // Disable from reset: compare, mode and achieved duty go to zero.
    add_fixed_row(1'b0, 0, 0, fixed_row(1, 0, 83, 999, 0, ModeLow, 1000, 0, 1000, 5000, 0));
    // Disable with a stray field is rejected.
    add_fixed_row(1'b0, 1, 0, fixed_row(0, 0, 83, 999, 0, ModeLow, 1000, 0, 1000, 5000, 0));
    add_row(1'b0, 0, 16383);
    // 1 kHz at 50 percent: divisor 2 (84e6 / 65536e3 rounds up), period 42000.
    add_fixed_row(1'b1, 1000, 5000,
                  fixed_row(1, 1, 1, 41999, 21000, ModePwm, 1000, 0, 1000, 5000, 5000));
    // Zero percent forces low, 100 percent forces high with compare at reload.
    add_row(1'b1, 1000, 49);
    add_row(1'b1, 1000, 0);
    add_row(1'b1, 1000, 9950);
    add_row(1'b1, 1000, 10000);
    add_row(1'b1, 1000, 150);
    // Frequency extremes: zero, the lowest and the highest accepted, one above and the field maximum.
    add_row(1'b1, 0, 5000);
    add_row(1'b1, 1, 5000);
    add_row(1'b1, 840000, 5000);
    add_row(1'b1, 840001, 5000);
    add_row(1'b1, 1048575, 5000);
    // Odd frequencies give nonzero error and uneven achieved duty.
    add_row(1'b1, 7, 3333);
    add_row(1'b1, 12345, 6789);
    add_row(1'b1, 777777, 2500);
    add_row(1'b1, 1000, 16383);
    add_row(1'b0, 0, 0);
  endfunction

  // Walk the directed table. Fixed rows are checked against the predictor here;
  // the block is checked against the predictor by the result checker.
  task automatic run_directed();
    request_t r;
    settings_t predicted;
    foreach (directed_rows[i]) begin
      r.enable = directed_rows[i].enable;
      r.freq = FreqW'(directed_rows[i].freq);
      r.duty = DutyW'(directed_rows[i].duty);
      send_request(r);
      if (directed_rows[i].has_fixed) begin
        predicted = pending_settings[pending_settings.size() - 1];
        compare_settings("table", directed_rows[i].fixed, predicted);
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // Configuration phases: clock, min and max frequency, including the extremes.
  typedef struct {
    longint unsigned clk;
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     items;
  } config_phase_t;

  config_phase_t config_phases[$] = '{
    '{84000000, 1, 840000, 400},
    '{1000000, 1, 1048575, 250},
    '{500000000, 1, 1048575, 250},
    '{536870911, 100, 1000, 150},
    '{0, 1, 1048575, 60},
    '{12000000, 1048575, 1048575, 60},
    '{250000000, 20000, 10, 60},
    '{72000000, 3, 200000, 400},
    '{84000000, 1, 840000, 250}
  };

  initial begin
    timer_clk = 84000000;
    min_hz = 1;
    max_hz = 840000;
    timer_state = reset_settings();
    build_directed_table();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Back-pressure test: the receiver stops for a long stretch while requests
    // keep coming, so the block holds its result and stalls its input.
    hold_off_cycles = 3000;
    run_random(8);

    // The sender pauses until every expected result has come.
    drain_results();

    foreach (config_phases[p]) begin
      drain_results();
      write_register(CfgClk, config_phases[p].clk);
      write_register(CfgMin, config_phases[p].lo);
      write_register(CfgMax, config_phases[p].hi);
      // One phase runs without idling on either side.
      sink_busy_mode = (p != 1);
      source_busy_mode = (p != 1);
      run_random(config_phases[p].items);
    end
    // An index past the register list must change nothing.
    drain_results();
    write_register(2'd3, 29'h1FFF_FFFF);
    run_random(40);

    stimulus_done = 1'b1;
    drain_results();
    repeat (400) @(posedge clk_i);

    if (pending_settings.size() != 0) begin
      $error("%0d expected results never arrived", pending_settings.size());
      fail_count++;
    end
    $display("Checked %0d results: %0d applied, %0d rejected, across %0d clock settings.",
             result_count, accept_count, reject_count, config_phases.size());
    $display("Output modes seen: forced low %0d, pwm %0d, forced high %0d.",
             mode_seen[0], mode_seen[1], mode_seen[2]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: about 1950 items, with stalls and the long hold-off, finish well
  // before 20 ms of simulated time.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
